@@ hdl/bfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bfs_pkg: shared types and constants for the BFS first-step finder
// Transaction payload structs, command and status codes, sizes.
// ----------------------------------------------------------------------------
package bfs_pkg;

    localparam int MAX_ROOMS_DEF = 1024;
    localparam int DIRS_DEF      = 6;
    localparam int ROOM_W        = 10;
    localparam int DIR_W         = 3;
    localparam int CMD_W         = 2;
    localparam int STAT_W        = 3;
    localparam int ZONE_SIZE     = 100;
    localparam logic [ROOM_W-1:0] LAST_ROOM_RST = 10'd1023;

    localparam logic [CMD_W-1:0] CMD_WR_EXIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_FLAGS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED   = 2'd3;

    localparam logic [STAT_W-1:0] ST_FOUND   = 3'd0;
    localparam logic [STAT_W-1:0] ST_THERE   = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_PATH = 3'd2;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 3'd3;
    localparam logic [STAT_W-1:0] ST_WR_DONE = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ROOM_W-1:0] room;
        logic [DIR_W-1:0]  direction;
        logic              exit_present;
        logic [ROOM_W-1:0] exit_destination;
        logic              no_track_flag;
        logic              no_mob_flag;
        logic [ROOM_W-1:0] target_room;
        logic              same_zone_only;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DIR_W-1:0]  first_direction;
    } t_out_item;

    // zone index for a 10-bit room: room / 100 via reciprocal 41/4096, corrected
    function automatic logic [3:0] zone_of(input logic [ROOM_W-1:0] r);
        logic [16:0] p;
        logic [3:0]  q;
        logic [10:0] rem;
        begin
            p   = 17'(r) * 17'd41;
            q   = p[15:12];
            rem = 11'(r) - 11'(q) * 11'(ZONE_SIZE);
            if (rem >= 11'(ZONE_SIZE)) q = q + 4'd1;
            zone_of = q;
        end
    endfunction

endpackage

@@ hdl/bfs_first_step_finder_core.sv @@
// ----------------------------------------------------------------------------
// bfs_first_step_finder_core: breadth-first first-step finder
// Room graph in block RAMs; FIFO BFS walks the queue memory per query.
// ----------------------------------------------------------------------------
// channel   dir  handshake      payload
// in        in   valid / stall  bfs_pkg::t_in_item
// out       out  valid / stall  bfs_pkg::t_out_item
// cfg       in   valid / ready  last_room (10 bits)
//
// A query first checks its rooms, then clears the marks of rooms 0..bound,
// then expands the source and each dequeued room (dequeue read and target
// compare for the latter), with an exit read, a flag/mark read and a push
// per direction. Reset: mark memory is cleared per query, exit and flag
// memories need a clearing pass over all MAX_ROOMS*DIRS exit slots after
// reset, during which no item is accepted.
// Output stall holds the result; a new item is accepted once the previous
// result has left.
module bfs_first_step_finder_core #(
    parameter int MAX_ROOMS = bfs_pkg::MAX_ROOMS_DEF,
    parameter int DIRS      = bfs_pkg::DIRS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  bfs_pkg::t_in_item         i_data,
    output logic                      o_valid,
    input  logic                      i_stall,
    output bfs_pkg::t_out_item        o_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bfs_pkg::ROOM_W-1:0] i_cfg_data
);
    localparam int RW    = $clog2(MAX_ROOMS);
    localparam int SLOTS = MAX_ROOMS * DIRS;
    localparam int SW    = $clog2(SLOTS);
    localparam int DW    = (DIRS > 1) ? $clog2(DIRS) : 1;
    localparam int QW    = RW + 1;

    typedef enum logic [8:0] {
        S_INIT  = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_CLEAR = 9'b000000100,
        S_EXIT  = 9'b000001000,
        S_CHECK = 9'b000010000,
        S_PUSH  = 9'b000100000,
        S_DEQ   = 9'b001000000,
        S_DEQ2  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    logic                           r_exit_pres [SLOTS];
    logic [bfs_pkg::ROOM_W-1:0]     r_exit_dest [SLOTS];
    logic [1:0]                     r_flags     [MAX_ROOMS];
    logic                           r_mark      [MAX_ROOMS];
    logic [RW-1:0]                  r_q_room    [MAX_ROOMS];
    logic [DW-1:0]                  r_q_dir     [MAX_ROOMS];

    t_state                   r_state;
    logic [SW:0]              r_init_cnt;
    logic [bfs_pkg::ROOM_W-1:0] r_last_room;
    bfs_pkg::t_in_item        r_item;
    bfs_pkg::t_out_item       r_out;
    logic                     r_out_valid;
    logic [RW:0]              r_clr;
    logic [QW-1:0]            r_rd_ptr, r_wr_ptr;
    logic [DW-1:0]            r_cur_dir;
    logic                     r_first;
    logic [DW-1:0]            r_d;
    logic [SW-1:0]            r_base;
    logic                     r_ex_pres;
    logic [bfs_pkg::ROOM_W-1:0] r_ex_dest;
    logic [1:0]               r_fl_rd;
    logic                     r_mk_rd;
    logic [RW-1:0]            r_q_room_rd;
    logic [DW-1:0]            r_q_dir_rd;

    logic [RW:0]              w_bound;
    logic                     w_accept;
    logic [SW-1:0]            w_slot;
    logic [RW-1:0]            w_src, w_tgt;
    logic                     w_ok;

    always_comb begin
        if (32'(r_last_room) > 32'(MAX_ROOMS - 1)) w_bound = (RW+1)'(MAX_ROOMS - 1);
        else w_bound = (RW+1)'(r_last_room);
    end

    assign o_stall     = (r_state != S_IDLE) || r_out_valid;
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;
    assign w_slot      = SW'(32'(r_item.room) * DIRS + 32'(r_item.direction));
    assign w_src       = RW'(r_item.room);
    assign w_tgt       = RW'(r_item.target_room);
    assign w_ok        = r_ex_pres && (32'(r_ex_dest) <= 32'(w_bound));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_cnt  <= '0;
            r_last_room <= bfs_pkg::LAST_ROOM_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_last_room <= i_cfg_data;
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_INIT: begin
                    r_exit_pres[SW'(r_init_cnt)] <= 1'b0;
                    if (32'(r_init_cnt) < MAX_ROOMS)
                        r_flags[RW'(r_init_cnt)] <= 2'b00;
                    if (32'(r_init_cnt) == SLOTS - 1) r_state <= S_IDLE;
                    r_init_cnt <= r_init_cnt + 1'b1;
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_item  <= i_data;
                        r_clr   <= '0;
                        r_first <= 1'b1;
                        r_out.first_direction <= '0;
                        case (i_data.command)
                            bfs_pkg::CMD_WR_EXIT, bfs_pkg::CMD_WR_FLAGS: begin
                                r_out.status <= bfs_pkg::ST_WR_DONE;
                                r_state      <= S_OUT;
                            end
                            bfs_pkg::CMD_QUERY: begin
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_out.status <= bfs_pkg::ST_ILLEGAL;
                                r_state      <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (r_item.command == bfs_pkg::CMD_WR_EXIT) begin
                        if (32'(r_item.room) < MAX_ROOMS && 32'(r_item.direction) < DIRS) begin
                            r_exit_pres[w_slot] <= r_item.exit_present;
                            r_exit_dest[w_slot] <= r_item.exit_destination;
                        end
                    end else if (r_item.command == bfs_pkg::CMD_WR_FLAGS) begin
                        if (32'(r_item.room) < MAX_ROOMS)
                            r_flags[RW'(r_item.room)] <=
                                {r_item.no_mob_flag, r_item.no_track_flag};
                    end
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_CLEAR: begin
                    if (r_clr == '0 && r_first) begin
                        r_first <= 1'b0;
                        if (32'(r_item.room) > 32'(w_bound) ||
                            32'(r_item.target_room) > 32'(w_bound)) begin
                            r_out.status <= bfs_pkg::ST_ILLEGAL;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_IDLE;
                        end else if (r_item.same_zone_only &&
                            bfs_pkg::zone_of(r_item.room) !=
                            bfs_pkg::zone_of(r_item.target_room)) begin
                            r_out.status <= bfs_pkg::ST_NO_PATH;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_IDLE;
                        end else if (r_item.room == r_item.target_room) begin
                            r_out.status <= bfs_pkg::ST_THERE;
                            r_out_valid  <= 1'b1;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_mark[RW'(r_clr)] <= (RW'(r_clr) == w_src);
                        if (r_clr == w_bound) begin
                            r_first   <= 1'b1;
                            r_rd_ptr  <= '0;
                            r_wr_ptr  <= '0;
                            r_cur_dir <= '0;
                            r_d       <= '0;
                            r_base    <= SW'(32'(w_src) * DIRS);
                            r_state   <= S_EXIT;
                        end
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_EXIT: begin
                    r_ex_pres <= r_exit_pres[r_base + SW'(r_d)];
                    r_ex_dest <= r_exit_dest[r_base + SW'(r_d)];
                    r_state   <= S_CHECK;
                end
                S_CHECK: begin
                    r_fl_rd <= r_flags[RW'(r_ex_dest)];
                    r_mk_rd <= r_mark[RW'(r_ex_dest)];
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (w_ok && r_fl_rd == 2'b00 && !r_mk_rd) begin
                        r_mark[RW'(r_ex_dest)]    <= 1'b1;
                        r_q_room[RW'(r_wr_ptr)]   <= RW'(r_ex_dest);
                        r_q_dir[RW'(r_wr_ptr)]    <= r_first ? r_d : r_cur_dir;
                        r_wr_ptr                  <= r_wr_ptr + 1'b1;
                    end
                    if (32'(r_d) == DIRS - 1) begin
                        r_state <= S_DEQ;
                        if (!r_first) r_rd_ptr <= r_rd_ptr + 1'b1;
                        r_first <= 1'b0;
                    end else begin
                        r_d     <= r_d + 1'b1;
                        r_state <= S_EXIT;
                    end
                end
                S_DEQ: begin
                    if (r_rd_ptr == r_wr_ptr) begin
                        r_out.status <= bfs_pkg::ST_NO_PATH;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_q_room_rd <= r_q_room[RW'(r_rd_ptr)];
                        r_q_dir_rd  <= r_q_dir[RW'(r_rd_ptr)];
                        r_state     <= S_DEQ2;
                    end
                end
                S_DEQ2: begin
                    if (r_q_room_rd == w_tgt) begin
                        r_out.status          <= bfs_pkg::ST_FOUND;
                        r_out.first_direction <= bfs_pkg::DIR_W'(r_q_dir_rd);
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end else begin
                        r_cur_dir <= r_q_dir_rd;
                        r_base    <= SW'(32'(r_q_room_rd) * DIRS);
                        r_d       <= '0;
                        r_state   <= S_EXIT;
                    end
                end
                default: r_state <= S_INIT;
            endcase
        end
    end

endmodule
